/* rtl/zcft_pkg.sv */
package zcft_pkg;

  // Fixed field widths of the frequency path.
  localparam int FREQ_W     = 24;
  localparam int COEFF_W    = 17;
  localparam int COEFF_FRAC = 16;
  localparam int RATE_W     = 18;
  localparam int REG_W      = 24;

  typedef logic [FREQ_W-1:0]  freq_t;
  typedef logic [COEFF_W-1:0] coeff_t;

  localparam freq_t  FREQ_MAX  = '1;
  localparam coeff_t COEFF_ONE = coeff_t'(1 << COEFF_FRAC);

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_INVERT      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEFF       = 3'd4;

  // Register values after reset.
  localparam int RST_THRESHOLD = 83886;
  localparam int RST_MAX_STEP  = 25600;
  localparam int RST_RATE      = 48000;
  localparam int RST_COEFF     = 5268;

endpackage

/* rtl/zcft_div.sv */
module zcft_div #(
  parameter int DIV_W = 26,
  parameter int CNT_W = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic [DIV_W-1:0] quot_o,
  output logic             done_o
);

  localparam int LEFT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  qr_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [LEFT_W-1:0] left_q;
  logic              done_q;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] sub;
  logic           ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of qr_q while quotient bits shift in at the bottom.
  assign trial = {rem_q, qr_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign sub   = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        left_q <= LEFT_W'(DIV_W);
      end else if (left_q != '0) begin
        left_q <= left_q - 1'b1;
        done_q <= (left_q == LEFT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qr_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (left_q != '0) begin
      rem_q <= ge ? sub[CNT_W-1:0] : trial[CNT_W-1:0];
      qr_q  <= {qr_q[DIV_W-2:0], ge};
    end
  end

  assign quot_o = qr_q;
  assign done_o = done_q;

endmodule

/* rtl/zcft_mul.sv */
module zcft_mul (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  zcft_pkg::freq_t                            a_i,
  input  zcft_pkg::coeff_t                           b_i,
  output logic [zcft_pkg::FREQ_W+zcft_pkg::COEFF_W-1:0] prod_o,
  output logic                                       done_o
);

  import zcft_pkg::*;

  localparam int LEFT_W = $clog2(COEFF_W + 1);

  logic [FREQ_W:0]   hi_q;
  coeff_t            lo_q;
  freq_t             a_q;
  logic [LEFT_W-1:0] left_q;
  logic              done_q;

  logic [FREQ_W:0] sum;

  // Shift-add over the multiplier bits, low bit first. The upper half of
  // the product accumulates while the lower half takes the bits shifted out.
  assign sum = hi_q + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        left_q <= LEFT_W'(COEFF_W);
      end else if (left_q != '0) begin
        left_q <= left_q - 1'b1;
        done_q <= (left_q == LEFT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      a_q  <= a_i;
    end else if (left_q != '0) begin
      hi_q <= {1'b0, sum[FREQ_W:1]};
      lo_q <= {sum[0], lo_q[COEFF_W-1:1]};
    end
  end

  assign prod_o = {hi_q[FREQ_W-1:0], lo_q};
  assign done_o = done_q;

endmodule

/* rtl/zero_crossing_frequency_tracker_core.sv */
// Zero-crossing frequency tracker. Each input word carries one signed sample;
// each sample yields one output word with the current frequency estimate
// (unsigned Q16.8 Hz) and two flags: an upward threshold crossing occurred,
// and the crossing's candidate frequency updated the estimate. A sample that
// does not lead to a division goes from the idle state to the finish state
// and enters the output register once that register is empty or being read.
// A crossing with a nonzero period count runs a serial divider, then a serial
// 17-bit multiplier for the smoothing step if the candidate is accepted. The
// divider and the multiplier each work one bit per cycle.
// One sample is in work at a time, and the next can be taken in the cycle
// after the previous word moves to the output register; the next may be
// accepted while a finished word still waits at the output.
module zero_crossing_frequency_tracker_core #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COUNT_WIDTH    = 20,
  parameter int FREQ_FRAC_BITS = 8
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]           s_axis_tdata_i,
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // Fields from bit 0: frequency.
  output logic [zcft_pkg::FREQ_W-1:0]                 m_axis_tdata_o,
  // Fields from bit 0: crossing, accepted.
  output logic [1:0]                                  m_axis_tuser_o,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  input  logic                                        cfg_we_i,
  input  logic [zcft_pkg::REG_IDX_W-1:0]              cfg_idx_i,
  input  logic [((SAMPLE_WIDTH > zcft_pkg::REG_W) ? SAMPLE_WIDTH
                 : zcft_pkg::REG_W)-1:0]              cfg_data_i
);

  import zcft_pkg::*;

  localparam int CFG_W   = (SAMPLE_WIDTH > REG_W) ? SAMPLE_WIDTH : REG_W;
  localparam int DIV_W   = RATE_W + FREQ_FRAC_BITS;
  localparam int QX_W    = (DIV_W > FREQ_W) ? DIV_W : FREQ_W + 1;
  localparam int PROD_W  = FREQ_W + COEFF_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [COUNT_WIDTH-1:0]         CNT_MAX = '1;
  localparam logic [PROD_W-1:0]              ROUND_HALF = PROD_W'(1 << (COEFF_FRAC - 1));

  // Configuration registers.
  logic                    invert_q;
  logic signed [CFG_W-1:0] thr_q;
  freq_t                   max_step_q;
  logic [RATE_W-1:0]       rate_q;
  coeff_t                  coeff_q;

  // Tracker state.
  logic [2:0]                     state_q, state_d;
  logic signed [SAMPLE_WIDTH-1:0] prev_q;
  logic [COUNT_WIDTH-1:0]         cnt_q;
  freq_t                          est_q;
  logic                           cross_q;
  logic                           acc_q;
  logic                           up_q;
  freq_t                          diff_q;

  // Output register.
  logic  m_valid_q;
  freq_t m_freq_q;
  logic  m_cross_q;
  logic  m_acc_q;

  logic                           in_acc;
  logic                           out_load;
  logic signed [SAMPLE_WIDTH-1:0] smp_raw;
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic signed [CFG_W-1:0]        smp_x;
  logic signed [CFG_W-1:0]        prev_x;
  logic                           crossed;
  logic                           div_start;
  logic                           div_done;
  logic [DIV_W-1:0]               div_quot;
  logic [QX_W-1:0]                quot_x;
  freq_t                          cand;
  logic                           up;
  freq_t                          diff;
  logic                           take;
  coeff_t                         coeff_eff;
  logic                           mul_start;
  logic                           mul_done;
  logic [PROD_W-1:0]              prod;
  logic [PROD_W-1:0]              rnd;
  logic [FREQ_W:0]                step_w;
  freq_t                          step;

  assign in_acc   = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready_i);

  // Negating the most negative sample saturates at the most positive value.
  assign smp_raw = signed'(s_axis_tdata_i[SAMPLE_WIDTH-1:0]);
  assign smp     = !invert_q ? smp_raw : ((smp_raw == SMP_MIN) ? SMP_MAX : -smp_raw);
  assign smp_x   = CFG_W'(smp);
  assign prev_x  = CFG_W'(prev_q);
  assign crossed = (prev_x <= thr_q) && (smp_x > thr_q);

  assign div_start = in_acc && crossed && (cnt_q != '0);

  zcft_div #(
    .DIV_W (DIV_W),
    .CNT_W (COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'(rate_q) << FREQ_FRAC_BITS),
    .divisor_i  (cnt_q),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  // Candidate saturates at the largest Q16.8 value.
  assign quot_x = QX_W'(div_quot);
  assign cand   = (quot_x[QX_W-1:FREQ_W] != '0) ? FREQ_MAX : quot_x[FREQ_W-1:0];
  assign up     = cand >= est_q;
  assign diff   = up ? cand - est_q : est_q - cand;
  assign take   = diff < max_step_q;

  assign coeff_eff = coeff_q[COEFF_W-1] ? COEFF_ONE : coeff_q;
  assign mul_start = (state_q == ST_CMP) && take;

  zcft_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (diff),
    .b_i     (coeff_eff),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  // Round half up at the coefficient's fraction, never past the candidate.
  assign rnd    = prod + ROUND_HALF;
  assign step_w = rnd[PROD_W-1:COEFF_FRAC];
  assign step   = (step_w > {1'b0, diff_q}) ? diff_q : step_w[FREQ_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = div_start ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: state_d = take ? ST_MUL : ST_FIN;
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: state_d = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q   <= 1'b0;
      thr_q      <= CFG_W'(RST_THRESHOLD);
      max_step_q <= FREQ_W'(RST_MAX_STEP);
      rate_q     <= RATE_W'(RST_RATE);
      coeff_q    <= COEFF_W'(RST_COEFF);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INVERT:      invert_q   <= cfg_data_i[0];
        REG_THRESHOLD:   thr_q      <= CFG_W'(signed'(cfg_data_i[SAMPLE_WIDTH-1:0]));
        REG_MAX_STEP:    max_step_q <= cfg_data_i[FREQ_W-1:0];
        REG_SAMPLE_RATE: rate_q     <= cfg_data_i[RATE_W-1:0];
        REG_COEFF:       coeff_q    <= cfg_data_i[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      prev_q    <= SMP_MAX;
      cnt_q     <= '0;
      est_q     <= '0;
      cross_q   <= 1'b0;
      acc_q     <= 1'b0;
      up_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        prev_q  <= smp;
        cross_q <= crossed;
        acc_q   <= 1'b0;
        // A crossing clears the count before this sample's increment.
        if (crossed) begin
          cnt_q <= COUNT_WIDTH'(1);
        end else if (cnt_q != CNT_MAX) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == ST_CMP) begin
        up_q <= up;
      end
      if (state_q == ST_UPD) begin
        est_q <= up_q ? est_q + step : est_q - step;
        acc_q <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP) begin
      diff_q <= diff;
    end
    if (out_load) begin
      m_freq_q  <= est_q;
      m_cross_q <= cross_q;
      m_acc_q   <= acc_q;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_freq_q;
  assign m_axis_tuser_o  = {m_acc_q, m_cross_q};

`ifndef SYNTHESIS
  // An estimate update only ever follows a crossing.
  a_acc_needs_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (!m_acc_q || m_cross_q))
    else $error("accepted flag without crossing");

  // The estimate moves only in the update step.
  a_est_only_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (est_q != $past(est_q)) |-> ($past(state_q) == ST_UPD))
    else $error("estimate changed outside update");

  // After any accepted sample the period count is nonzero.
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (cnt_q != '0))
    else $error("period count zero after sample");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider done outside divide state");
`endif

endmodule
